// ===== design/vtp_pkg.sv =====
`timescale 1ns / 1ps

package vtp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ELEM_W      = 32;
	localparam int CMD_W       = 3;
	localparam int IDX_W       = 4;
	localparam int MAT_N       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// Product of an element and a vertex coordinate, the sum of three of them plus a
	// translation term, and the dot product after dropping the fraction bits.
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int DOT_W  = SUM_W - FRAC_BITS;
	// Quotient bits kept by the divider; anything larger saturates anyway.
	localparam int QUO_W  = VALUE_WIDTH + 1;
	localparam int DIV_LAT = QUO_W + 1;
	// Viewport mapping widths.
	localparam int MAPP_W = VALUE_WIDTH + 1 + CFG_W + 1;
	localparam int MAPS_W = MAPP_W + 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 3'd0,
		CMD_HOMOG   = 3'd1,
		CMD_POINT   = 3'd2,
		CMD_NORMAL  = 3'd3,
		CMD_PROJECT = 3'd4
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

	typedef logic signed [ELEM_W-1:0]      elem_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic signed [DOT_W-1:0]       dot_t;
	typedef logic signed [VALUE_WIDTH-1:0] val_t;

	localparam elem_t FX_ONE  = elem_t'(1 << FRAC_BITS);
	localparam val_t  VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam val_t  VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef struct packed {
		cmd_t  cmd;
		elem_t x;
		elem_t y;
		elem_t z;
	} vtx_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		val_t v;
		logic s;
	} clamp_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       zw;
		logic [2:0] neg;
		val_t       rx;
		val_t       ry;
		val_t       rz;
		val_t       rw;
		logic       sat;
	} side_t;

endpackage

// ===== design/vtp_queue.sv =====
`timescale 1ns / 1ps

module vtp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vtp_pkg::vtx_t  wdata,
	input  logic           pop,
	output vtp_pkg::vtx_t  rdata,
	output vtp_pkg::q_stat_t stat
);
	import vtp_pkg::*;

	vtx_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== design/vtp_front.sv =====
`timescale 1ns / 1ps

module vtp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vtp_pkg::CMD_W-1:0]     command,
	input  logic [vtp_pkg::IDX_W-1:0]     elem_index,
	input  vtp_pkg::elem_t                elem_value,
	input  vtp_pkg::elem_t                in_x,
	input  vtp_pkg::elem_t                in_y,
	input  vtp_pkg::elem_t                in_z,
	input  vtp_pkg::q_stat_t              q_stat,
	output logic                          q_push,
	output vtp_pkg::vtx_t                 q_wdata,
	output vtp_pkg::elem_t                mat [vtp_pkg::MAT_N]
);
	import vtp_pkg::*;

	cmd_t  cmd;
	logic  is_load;
	logic  is_vtx;
	elem_t mat_q [MAT_N];

	assign cmd = cmd_t'(command);

	// A load waits until every queued vertex has been multiplied, so a
	// vertex always sees the matrix that stood when it was accepted.
	always_comb begin
		is_load = 1'b0;
		is_vtx  = 1'b0;
		unique case (cmd) inside
			CMD_LOAD:                                      is_load = 1'b1;
			CMD_HOMOG, CMD_POINT, CMD_NORMAL, CMD_PROJECT: is_vtx  = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = is_load ? q_stat.empty : (is_vtx ? !q_stat.full : 1'b1);
	assign q_push   = in_valid && is_vtx && !q_stat.full;
	assign q_wdata  = '{cmd: cmd, x: in_x, y: in_y, z: in_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_N; i++) begin
				mat_q[i] <= (i % 5 == 0) ? FX_ONE : '0;
			end
		end else if (in_valid && is_load && q_stat.empty) begin
			mat_q[elem_index] <= elem_value;
		end
	end

	assign mat = mat_q;

endmodule

// ===== design/vtp_div.sv =====
`timescale 1ns / 1ps

module vtp_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [vtp_pkg::DOT_W-1:0]  num,
	input  logic [vtp_pkg::DOT_W-1:0]  den,
	output logic [vtp_pkg::QUO_W-1:0]  quo,
	output logic                       ovf
);
	import vtp_pkg::*;

	localparam int HI_SH = QUO_W - FRAC_BITS;

	// Restoring division of num * 2^FRAC_BITS by den, one quotient bit per stage.
	// The first stage flags quotients that do not fit in QUO_W bits.
	logic [DOT_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [DOT_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];
	logic [DOT_W-1:0] num_hi;

	assign num_hi = num >> HI_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_hi;
			low_s[0] <= {num[HI_SH-1:0], {FRAC_BITS{1'b0}}};
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (num_hi >= den);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DOT_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k], low_s[k][QUO_W-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DOT_W'(trial - {1'b0, den_s[k]}) : DOT_W'(trial);
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k + 1 < QUO_W) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k+1] <= low_s[k] << 1;
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

// ===== design/vtp_back.sv =====
`timescale 1ns / 1ps

module vtp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vtp_pkg::q_stat_t              q_stat,
	input  vtp_pkg::vtx_t                 q_rdata,
	output logic                          q_pop,
	input  vtp_pkg::elem_t                mat [vtp_pkg::MAT_N],
	input  logic                          cfg_we,
	input  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtp_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vtp_pkg::elem_t                out_x,
	output vtp_pkg::elem_t                out_y,
	output vtp_pkg::elem_t                out_z,
	output vtp_pkg::elem_t                out_w,
	output logic                          zero_w,
	output logic                          saturated
);
	import vtp_pkg::*;

	typedef logic signed [MAPP_W-1:0] mapp_t;
	typedef logic signed [MAPS_W-1:0] maps_t;
	typedef logic signed [VALUE_WIDTH:0] ext_t;

	function automatic clamp_t clamp_dot(input dot_t v);
		clamp_t r;
		r.s = (v[DOT_W-1:VALUE_WIDTH-1] != {(DOT_W-VALUE_WIDTH+1){v[DOT_W-1]}});
		r.v = r.s ? (v[DOT_W-1] ? VAL_MIN : VAL_MAX) : val_t'(v);
		return r;
	endfunction

	function automatic clamp_t clamp_map(input maps_t v);
		clamp_t r;
		r.s = (v[MAPS_W-1:VALUE_WIDTH-1] != {(MAPS_W-VALUE_WIDTH+1){v[MAPS_W-1]}});
		r.v = r.s ? (v[MAPS_W-1] ? VAL_MIN : VAL_MAX) : val_t'(v);
		return r;
	endfunction

	// Viewport registers.
	logic signed [CFG_W-1:0] left_q;
	logic signed [CFG_W-1:0] top_q;
	logic [CFG_W-1:0]        width_q;
	logic [CFG_W-1:0]        height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEFT:   left_q   <= cfg_wdata;
				CFG_TOP:    top_q    <= cfg_wdata;
				CFG_WIDTH:  width_q  <= cfg_wdata;
				CFG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The whole back pipeline moves together whenever the output register is free.
	logic adv;
	logic out_valid_q;
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && !q_stat.empty;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic vd_s [DIV_LAT];

	// Stage 1: twelve element products.
	prod_t prod_s1 [4][3];
	elem_t trans_s1 [4];
	cmd_t  cmd_s1;
	elem_t vin [3];

	assign vin[0] = q_rdata.x;
	assign vin[1] = q_rdata.y;
	assign vin[2] = q_rdata.z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[c][r] <= prod_t'(mat[r*4+c]) * prod_t'(vin[r]);
				end
				trans_s1[c] <= mat[12+c];
			end
			cmd_s1 <= q_rdata.cmd;
		end
	end

	// Stage 2: column sums, floored to the fraction width.
	dot_t dot_c [4];
	dot_t dot_s2 [4];
	cmd_t cmd_s2;

	always_comb begin
		sum_t acc;
		for (int c = 0; c < 4; c++) begin
			acc = sum_t'(prod_s1[c][0]) + sum_t'(prod_s1[c][1]) + sum_t'(prod_s1[c][2]);
			if (c == 3 || cmd_s1 != CMD_NORMAL) begin
				acc = acc + (sum_t'(trans_s1[c]) <<< FRAC_BITS);
			end
			dot_c[c] = dot_t'(acc >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s2 <= dot_c;
			cmd_s2 <= cmd_s1;
		end
	end

	// Stage 3: direct results, signs and magnitudes for the divider.
	side_t            side_c;
	side_t            side_s3;
	logic [DOT_W-1:0] nmag_c [3];
	logic [DOT_W-1:0] nmag_s3 [3];
	logic [DOT_W-1:0] dmag_s3;
	clamp_t           cl [4];

	always_comb begin
		for (int i = 0; i < 4; i++) cl[i] = clamp_dot(dot_s2[i]);
		side_c     = '0;
		side_c.cmd = cmd_s2;
		side_c.zw  = (dot_s2[3] == '0);
		for (int i = 0; i < 3; i++) begin
			side_c.neg[i] = dot_s2[i][DOT_W-1] ^ dot_s2[3][DOT_W-1];
			nmag_c[i] = dot_s2[i][DOT_W-1] ? DOT_W'(-dot_s2[i]) : DOT_W'(dot_s2[i]);
		end
		side_c.rx = cl[0].v;
		side_c.ry = cl[1].v;
		side_c.rz = cl[2].v;
		if (cmd_s2 == CMD_HOMOG) begin
			side_c.rw  = cl[3].v;
			side_c.sat = cl[0].s | cl[1].s | cl[2].s | cl[3].s;
		end else begin
			side_c.sat = cl[0].s | cl[1].s | cl[2].s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_c;
			nmag_s3 <= nmag_c;
			dmag_s3 <= dot_s2[3][DOT_W-1] ? DOT_W'(-dot_s2[3]) : DOT_W'(dot_s2[3]);
		end
	end

	// Three dividers in lock step; side data rides a matching delay line.
	logic [QUO_W-1:0] quo [3];
	logic             ovf [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vtp_div u_div (
			.clk (clk),
			.en  (adv),
			.num (nmag_s3[i]),
			.den (dmag_s3),
			.quo (quo[i]),
			.ovf (ovf[i])
		);
	end

	side_t side_d [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s3;
			for (int k = 1; k < DIV_LAT; k++) side_d[k] <= side_d[k-1];
		end
	end

	// Stage 4: signed, clamped quotients.
	val_t  dv_c [3];
	logic  dsat_c;
	val_t  dv_s4 [3];
	logic  dsat_s4;
	side_t side_s4;

	always_comb begin
		dsat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (side_d[DIV_LAT-1].neg[i]) begin
				if (ovf[i] || quo[i][VALUE_WIDTH] ||
				    (quo[i][VALUE_WIDTH-1] && quo[i][VALUE_WIDTH-2:0] != '0)) begin
					dv_c[i] = VAL_MIN;
					dsat_c  = 1'b1;
				end else begin
					dv_c[i] = val_t'(-quo[i]);
				end
			end else begin
				if (ovf[i] || quo[i][VALUE_WIDTH:VALUE_WIDTH-1] != '0) begin
					dv_c[i] = VAL_MAX;
					dsat_c  = 1'b1;
				end else begin
					dv_c[i] = val_t'(quo[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s4   <= dv_c;
			dsat_s4 <= dsat_c;
			side_s4 <= side_d[DIV_LAT-1];
		end
	end

	// Stage 5: viewport products.
	mapp_t mx_s5;
	mapp_t my_s5;
	ext_t  zs_s5;
	val_t  dv_s5 [3];
	logic  dsat_s5;
	side_t side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s5 <= mapp_t'(ext_t'(FX_ONE) + ext_t'(dv_s4[0])) *
			         mapp_t'($signed({1'b0, width_q}));
			my_s5 <= mapp_t'(ext_t'(FX_ONE) - ext_t'(dv_s4[1])) *
			         mapp_t'($signed({1'b0, height_q}));
			zs_s5   <= ext_t'(FX_ONE) + ext_t'(dv_s4[2]);
			dv_s5   <= dv_s4;
			dsat_s5 <= dsat_s4;
			side_s5 <= side_s4;
		end
	end

	// Stage 6: offsets, final clamp, mode select into the output register.
	clamp_t px, py;
	val_t   pz;
	val_t   rx_c, ry_c, rz_c, rw_c;
	logic   zw_c, sat_c;

	always_comb begin
		px = clamp_map(maps_t'(mx_s5 >>> 1) + (maps_t'(left_q) <<< FRAC_BITS));
		py = clamp_map(maps_t'(my_s5 >>> 1) + (maps_t'(top_q) <<< FRAC_BITS));
		pz = val_t'(zs_s5 >>> 1);
		rx_c  = side_s5.rx;
		ry_c  = side_s5.ry;
		rz_c  = side_s5.rz;
		rw_c  = side_s5.rw;
		zw_c  = 1'b0;
		sat_c = side_s5.sat;
		if (side_s5.cmd == CMD_POINT || side_s5.cmd == CMD_PROJECT) begin
			rw_c = '0;
			if (side_s5.zw) begin
				rx_c  = '0;
				ry_c  = '0;
				rz_c  = '0;
				zw_c  = 1'b1;
				sat_c = 1'b0;
			end else if (side_s5.cmd == CMD_POINT) begin
				rx_c  = dv_s5[0];
				ry_c  = dv_s5[1];
				rz_c  = dv_s5[2];
				sat_c = dsat_s5;
			end else begin
				rx_c  = px.v;
				ry_c  = py.v;
				rz_c  = pz;
				sat_c = dsat_s5 | px.s | py.s;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) vd_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= q_pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			vd_s[0] <= v_s3;
			for (int k = 1; k < DIV_LAT; k++) vd_s[k] <= vd_s[k-1];
			v_s4        <= vd_s[DIV_LAT-1];
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	elem_t out_x_q, out_y_q, out_z_q, out_w_q;
	logic  zero_w_q, sat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q  <= elem_t'(rx_c);
			out_y_q  <= elem_t'(ry_c);
			out_z_q  <= elem_t'(rz_c);
			out_w_q  <= elem_t'(rw_c);
			zero_w_q <= zw_c;
			sat_q    <= sat_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign out_w     = out_w_q;
	assign zero_w    = zero_w_q;
	assign saturated = sat_q;

endmodule

// ===== design/vertex_transform_project.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    command, elem_index, elem_value, in_x, in_y, in_z
// result    out        out_valid / out_ready  out_x, out_y, out_z, out_w, zero_w, saturated
// config    in         cfg_we (no wait)       cfg_index, cfg_wdata
//
// Vertex commands are taken one per clock while the four-entry queue has room; a result
// then passes through products and sums, the per-bit divider pipeline and viewport math
// before it leaves.
// A matrix load is taken only once the queue is empty, so it waits for queued vertices.
// Reset loads the identity matrix and clears the viewport; no clearing pass is needed.
// A stall on the output freezes the back pipeline; the front keeps filling the queue.

module vertex_transform_project (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vtp_pkg::CMD_W-1:0]     command,
	input  logic [vtp_pkg::IDX_W-1:0]     elem_index,
	input  vtp_pkg::elem_t                elem_value,
	input  vtp_pkg::elem_t                in_x,
	input  vtp_pkg::elem_t                in_y,
	input  vtp_pkg::elem_t                in_z,
	input  logic                          cfg_we,
	input  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtp_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vtp_pkg::elem_t                out_x,
	output vtp_pkg::elem_t                out_y,
	output vtp_pkg::elem_t                out_z,
	output vtp_pkg::elem_t                out_w,
	output logic                          zero_w,
	output logic                          saturated
);
	import vtp_pkg::*;

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	vtx_t    q_wdata;
	vtx_t    q_rdata;
	elem_t   mat [MAT_N];

	// The front classifies each transfer: loads update the matrix, vertices are queued,
	// unknown commands are dropped.
	vtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_wdata    (q_wdata),
		.mat        (mat)
	);

	vtp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// The back uses the matrix for a vertex only in the cycle it pops that vertex.
	vtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.mat       (mat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.zero_w    (zero_w),
		.saturated (saturated)
	);

endmodule

// ===== design/vtp_checker.sv =====
`timescale 1ns / 1ps

module vtp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [vtp_pkg::CMD_W-1:0]     command,
	input logic                          out_valid,
	input logic                          out_ready,
	input vtp_pkg::elem_t                out_x,
	input vtp_pkg::elem_t                out_y,
	input vtp_pkg::elem_t                out_z,
	input vtp_pkg::elem_t                out_w,
	input logic                          zero_w,
	input logic                          saturated
);
	import vtp_pkg::*;

	logic vtx_xfer;
	assign vtx_xfer = in_valid && in_ready &&
	                  (command == CMD_HOMOG || command == CMD_POINT ||
	                   command == CMD_NORMAL || command == CMD_PROJECT);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
		$stable(out_z) && $stable(out_w) && $stable(zero_w) && $stable(saturated))
		else $error("result changed while stalled");

	// A zero divisor clears every value field and never reports saturation.
	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_w |-> !saturated && out_x == '0 && out_y == '0 &&
		out_z == '0 && out_w == '0)
		else $error("zero divisor result not cleared");

	// A vertex transfer leaves the queue non-empty, so a load cannot follow at once.
	a_load_order: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_xfer |=> !(in_valid && in_ready && command == CMD_LOAD))
		else $error("matrix load overtook a queued vertex");

	// No result leaves in the cycle right after reset is released.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (.*);
